[design/flha_pkg.sv]
// Shared constants, codes and types of the free-list heap allocator.
package flha_pkg;

	localparam int OFS_W       = 13;
	localparam int REQ_W       = 12;
	localparam int HDR_BYTES   = 16;
	localparam int SIZE_WORD   = 8;
	localparam int FIRST_BLOCK = 32;
	localparam int APB_AW      = 3;
	localparam int APB_DW      = 32;

	localparam logic [APB_AW-1:0] ADDR_FIT_POLICY = 3'd0;

	typedef enum logic [1:0] {
		POL_FIRST = 2'd0,
		POL_BEST  = 2'd1,
		POL_WORST = 2'd2
	} flha_policy_t;

	typedef enum logic [1:0] {
		ST_GRANT   = 2'd0,
		ST_NOSPACE = 2'd1,
		ST_FREED   = 2'd2
	} flha_status_t;

	typedef enum logic [4:0] {
		S_INIT,
		S_IDLE,
		S_A_RD,
		S_A_CHK,
		S_A_DEC,
		S_A_W1,
		S_A_W2,
		S_A_W3,
		S_F_RD,
		S_F_CHK,
		S_F_INS,
		S_F_LINK,
		S_M_RD,
		S_M_CHK1,
		S_M_CHK2,
		S_M_W2,
		S_DONE
	} flha_state_t;

	typedef struct packed {
		logic             mode;
		logic [REQ_W-1:0] req_size;
		logic [OFS_W-1:0] release_offset;
	} flha_cmd_t;

	typedef struct packed {
		logic [OFS_W-1:0] data_offset;
		flha_status_t     status;
	} flha_res_t;

endpackage

[design/flha_if.sv]
// Request and response channel interfaces of the free-list heap allocator.
interface flha_req_if import flha_pkg::*; ();
	logic             valid;
	logic             ready;
	logic             mode;
	logic [REQ_W-1:0] req_size;
	logic [OFS_W-1:0] release_offset;

	modport source(output valid, output mode, output req_size, output release_offset,
		input ready);
	modport sink(input valid, input mode, input req_size, input release_offset,
		output ready);
endinterface

interface flha_rsp_if import flha_pkg::*; ();
	logic             valid;
	logic             ready;
	logic [OFS_W-1:0] data_offset;
	logic [1:0]       status;

	modport source(output valid, output data_offset, output status, input ready);
	modport sink(input valid, input data_offset, input status, output ready);
endinterface

[design/flha_seq.sv]
// Heap sequencer: header stores, list walker and result register.
module flha_seq import flha_pkg::*; #(
	parameter int ARENA_BYTES = 4096
) (
	input  logic         clk,
	input  logic         arst_n,
	input  flha_policy_t fit_policy,
	input  logic         cmd_valid,
	output logic         cmd_ready,
	input  flha_cmd_t    cmd,
	output logic         res_valid,
	input  logic         res_ready,
	output flha_res_t    res
);

	localparam int IW  = $clog2(ARENA_BYTES);
	localparam int SW  = IW + 1;
	localparam int CW  = ((SW > OFS_W) ? SW : OFS_W) + 1;
	localparam int STW = IW + 2;
	localparam logic [CW-1:0]  ARENA_C    = CW'(ARENA_BYTES);
	localparam logic [STW-1:0] SEARCH_MAX = STW'(ARENA_BYTES);
	localparam logic [STW-1:0] MERGE_MAX  = STW'(2 * ARENA_BYTES);
	localparam logic [IW-1:0]  FIRST_IDX  = IW'(FIRST_BLOCK);
	localparam logic [SW-1:0]  INIT_SIZE  = SW'(ARENA_BYTES - FIRST_BLOCK);

	logic [SW-1:0] size_mem [ARENA_BYTES];
	logic [IW-1:0] next_mem [ARENA_BYTES];

	flha_state_t    state_q, state_d;
	logic [IW-1:0]  head_q, head_d, cur_q, cur_d, prev_q, prev_d, blk_q, blk_d;
	logic [IW-1:0]  pick_q, pick_d, pick_prev_q, pick_prev_d, pick_next_q, pick_next_d;
	logic [IW-1:0]  nbr_q, nbr_d, nb_q, nb_d;
	logic [SW-1:0]  pick_size_q, pick_size_d, asize_q, asize_d, rem_q, rem_d;
	logic [CW-1:0]  need_q, need_d;
	logic [STW-1:0] steps_q, steps_d;
	logic           split_q, split_d, res_valid_q, res_valid_d;
	flha_res_t      ans_q, ans_d, res_q, res_d;

	logic [SW-1:0]  size_rd_q;
	logic [IW-1:0]  next_rd_q;
	logic           rd_en, sz_we, nx_we;
	logic [IW-1:0]  rd_addr, sz_wa, nx_wa, nx_wd;
	logic [SW-1:0]  sz_wd;

	logic [CW-1:0]  rel_ext, blk_full, rem_full, nb_full;
	logic [SW:0]    sum;
	logic           fits, better;
	logic [IW-1:0]  link;

	always_ff @(posedge clk) begin
		if (sz_we) size_mem[sz_wa] <= sz_wd;
		if (nx_we) next_mem[nx_wa] <= nx_wd;
		if (rd_en) begin
			size_rd_q <= size_mem[rd_addr];
			next_rd_q <= next_mem[rd_addr];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_INIT;
			head_q      <= FIRST_IDX;
			res_valid_q <= 1'b0;
		end else begin
			state_q     <= state_d;
			head_q      <= head_d;
			res_valid_q <= res_valid_d;
		end
	end

	always_ff @(posedge clk) begin
		cur_q       <= cur_d;
		prev_q      <= prev_d;
		blk_q       <= blk_d;
		pick_q      <= pick_d;
		pick_prev_q <= pick_prev_d;
		pick_next_q <= pick_next_d;
		pick_size_q <= pick_size_d;
		nbr_q       <= nbr_d;
		nb_q        <= nb_d;
		asize_q     <= asize_d;
		rem_q       <= rem_d;
		need_q      <= need_d;
		steps_q     <= steps_d;
		split_q     <= split_d;
		ans_q       <= ans_d;
		res_q       <= res_d;
	end

	always_comb begin
		state_d     = state_q;
		head_d      = head_q;
		cur_d       = cur_q;
		prev_d      = prev_q;
		blk_d       = blk_q;
		pick_d      = pick_q;
		pick_prev_d = pick_prev_q;
		pick_next_d = pick_next_q;
		pick_size_d = pick_size_q;
		nbr_d       = nbr_q;
		nb_d        = nb_q;
		asize_d     = asize_q;
		rem_d       = rem_q;
		need_d      = need_q;
		steps_d     = steps_q;
		split_d     = split_q;
		ans_d       = ans_q;
		res_d       = res_q;
		res_valid_d = res_valid_q && !res_ready;
		cmd_ready   = 1'b0;
		rd_en       = 1'b0;
		rd_addr     = cur_q;
		sz_we       = 1'b0;
		sz_wa       = cur_q;
		sz_wd       = '0;
		nx_we       = 1'b0;
		nx_wa       = cur_q;
		nx_wd       = '0;
		rel_ext     = CW'(cmd.release_offset);
		blk_full    = rel_ext - CW'(SIZE_WORD);
		rem_full    = CW'(pick_size_q) - need_q;
		nb_full     = CW'(pick_q) + need_q;
		sum         = {1'b0, asize_q} + {1'b0, size_rd_q};
		fits        = CW'(size_rd_q) >= need_q;
		better      = (pick_q == '0)
			|| (fit_policy == POL_BEST && size_rd_q < pick_size_q)
			|| (fit_policy == POL_WORST && size_rd_q > pick_size_q);
		link        = split_q ? nb_q : pick_next_q;

		case (state_q)
			S_INIT: begin
				sz_we   = 1'b1;
				sz_wa   = FIRST_IDX;
				sz_wd   = INIT_SIZE;
				nx_we   = 1'b1;
				nx_wa   = FIRST_IDX;
				state_d = S_IDLE;
			end
			S_IDLE: begin
				cmd_ready = 1'b1;
				if (cmd_valid) begin
					cur_d       = head_q;
					prev_d      = '0;
					steps_d     = '0;
					pick_d      = '0;
					pick_prev_d = '0;
					pick_next_d = '0;
					pick_size_d = '0;
					if (!cmd.mode) begin
						need_d  = CW'(cmd.req_size) + CW'(HDR_BYTES);
						state_d = S_A_RD;
					end else if (rel_ext < CW'(SIZE_WORD + FIRST_BLOCK)
						|| blk_full >= ARENA_C) begin
						ans_d   = '{data_offset: '0, status: ST_FREED};
						state_d = S_DONE;
					end else begin
						blk_d   = blk_full[IW-1:0];
						state_d = S_F_RD;
					end
				end
			end
			S_A_RD: begin
				if (cur_q != '0 && steps_q < SEARCH_MAX) begin
					rd_en   = 1'b1;
					state_d = S_A_CHK;
				end else begin
					state_d = S_A_DEC;
				end
			end
			S_A_CHK: begin
				if (fits && (fit_policy == POL_FIRST || better)) begin
					pick_d      = cur_q;
					pick_prev_d = prev_q;
					pick_size_d = size_rd_q;
					pick_next_d = next_rd_q;
				end
				if (fits && fit_policy == POL_FIRST) begin
					state_d = S_A_DEC;
				end else begin
					prev_d  = cur_q;
					cur_d   = next_rd_q;
					steps_d = steps_q + 1'b1;
					state_d = S_A_RD;
				end
			end
			S_A_DEC: begin
				if (pick_q == '0 || fit_policy > POL_WORST) begin
					ans_d   = '{data_offset: '0, status: ST_NOSPACE};
					state_d = S_DONE;
				end else begin
					split_d = rem_full >= CW'(HDR_BYTES) && nb_full < ARENA_C;
					nb_d    = nb_full[IW-1:0];
					rem_d   = rem_full[SW-1:0];
					state_d = S_A_W1;
				end
			end
			S_A_W1: begin
				sz_we   = split_q;
				sz_wa   = pick_q;
				sz_wd   = need_q[SW-1:0];
				nx_we   = split_q;
				nx_wa   = nb_q;
				nx_wd   = pick_next_q;
				state_d = S_A_W2;
			end
			S_A_W2: begin
				sz_we   = split_q;
				sz_wa   = nb_q;
				sz_wd   = rem_q;
				nx_we   = 1'b1;
				nx_wa   = pick_q;
				state_d = S_A_W3;
			end
			S_A_W3: begin
				if (pick_prev_q == '0) begin
					head_d = link;
				end else begin
					nx_we = 1'b1;
					nx_wa = pick_prev_q;
					nx_wd = link;
				end
				ans_d.data_offset = OFS_W'(CW'(pick_q) + CW'(SIZE_WORD));
				ans_d.status      = ST_GRANT;
				state_d           = S_DONE;
			end
			S_F_RD: begin
				if (cur_q != '0 && blk_q > cur_q && steps_q < SEARCH_MAX) begin
					rd_en   = 1'b1;
					state_d = S_F_CHK;
				end else begin
					state_d = S_F_INS;
				end
			end
			S_F_CHK: begin
				prev_d  = cur_q;
				cur_d   = next_rd_q;
				steps_d = steps_q + 1'b1;
				state_d = S_F_RD;
			end
			S_F_INS: begin
				if (cur_q == blk_q) begin
					ans_d   = '{data_offset: '0, status: ST_FREED};
					state_d = S_DONE;
				end else begin
					nx_we   = 1'b1;
					nx_wa   = blk_q;
					nx_wd   = cur_q;
					state_d = S_F_LINK;
				end
			end
			S_F_LINK: begin
				if (prev_q == '0) begin
					head_d = blk_q;
					cur_d  = blk_q;
				end else begin
					nx_we = 1'b1;
					nx_wa = prev_q;
					nx_wd = blk_q;
					cur_d = head_q;
				end
				steps_d = '0;
				state_d = S_M_RD;
			end
			S_M_RD: begin
				if (cur_q != '0 && steps_q < MERGE_MAX) begin
					rd_en   = 1'b1;
					state_d = S_M_CHK1;
				end else begin
					ans_d   = '{data_offset: '0, status: ST_FREED};
					state_d = S_DONE;
				end
			end
			S_M_CHK1: begin
				steps_d = steps_q + 1'b1;
				if (next_rd_q != '0 && next_rd_q > cur_q
					&& {1'b0, next_rd_q - cur_q} == size_rd_q) begin
					nbr_d   = next_rd_q;
					asize_d = size_rd_q;
					rd_en   = 1'b1;
					rd_addr = next_rd_q;
					state_d = S_M_CHK2;
				end else begin
					cur_d   = next_rd_q;
					state_d = S_M_RD;
				end
			end
			S_M_CHK2: begin
				sz_we   = 1'b1;
				sz_wd   = sum[SW] ? '1 : sum[SW-1:0];
				nx_we   = 1'b1;
				nx_wd   = next_rd_q;
				state_d = S_M_W2;
			end
			S_M_W2: begin
				sz_we   = 1'b1;
				sz_wa   = nbr_q;
				nx_we   = 1'b1;
				nx_wa   = nbr_q;
				state_d = S_M_RD;
			end
			S_DONE: begin
				if (!res_valid_q || res_ready) begin
					res_d       = ans_q;
					res_valid_d = 1'b1;
					state_d     = S_IDLE;
				end
			end
			default: state_d = S_IDLE;
		endcase
	end

	assign res_valid = res_valid_q;
	assign res       = res_q;

endmodule

[design/free_list_heap_allocator.sv]
// Top level of the free-list heap allocator: channels, register port, sequencer.
//
//  channel | direction | transaction payload
//  --------+-----------+---------------------------------------------------
//  req     | in        | mode, req_size, release_offset
//  rsp     | out       | data_offset, status
//  apb     | in/out    | fit_policy register at byte address 0
//
// One transaction at a time; req is not ready while the list is walked.
// Allocate: free-list blocks are read in turn (a header read through the
// registered store port, then a compare); the chosen block is then split as
// needed and relinked. Free: the walk runs to the insert point, the block is
// linked in, and a merge pass reads each list block and merges adjacent pairs.
// After reset, the first free block header is seeded before req is ready.
// A stalled rsp holds its result; the next req may be taken meanwhile, and its
// result waits in the sequencer until the output register frees up.
module free_list_heap_allocator import flha_pkg::*; #(
	parameter int ARENA_BYTES = 4096
) (
	input  logic              clk,
	input  logic              arst_n,
	flha_req_if.sink          req,
	flha_rsp_if.source        rsp,
	input  logic              psel,
	input  logic              penable,
	input  logic              pwrite,
	input  logic [APB_AW-1:0] paddr,
	input  logic [APB_DW-1:0] pwdata,
	output logic [APB_DW-1:0] prdata,
	output logic              pready
);

	flha_policy_t fit_policy_q;
	flha_cmd_t    cmd;
	flha_res_t    res;
	logic         cfg_write;

	// Register write lands on the access phase; no wait states.
	assign pready    = 1'b1;
	assign cfg_write = psel && penable && pwrite && pready && paddr == ADDR_FIT_POLICY;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fit_policy_q <= POL_FIRST;
		end else if (cfg_write) begin
			fit_policy_q <= flha_policy_t'(pwdata[1:0]);
		end
	end

	// Read back the policy; unmapped addresses read zero.
	assign prdata = (paddr == ADDR_FIT_POLICY) ? APB_DW'(fit_policy_q) : '0;

	// Pack the request transaction for the sequencer.
	assign cmd = '{mode: req.mode, req_size: req.req_size,
		release_offset: req.release_offset};

	flha_seq #(
		.ARENA_BYTES(ARENA_BYTES)
	) u_seq (
		.clk       (clk),
		.arst_n    (arst_n),
		.fit_policy(fit_policy_q),
		.cmd_valid (req.valid),
		.cmd_ready (req.ready),
		.cmd       (cmd),
		.res_valid (rsp.valid),
		.res_ready (rsp.ready),
		.res       (res)
	);

	// Unpack the response transaction.
	assign rsp.data_offset = res.data_offset;
	assign rsp.status      = res.status;

endmodule

[design/flha_checker.sv]
// Port-level assertions for the free-list heap allocator, bound to the top level.
module flha_checker import flha_pkg::*; (
	input logic             clk,
	input logic             arst_n,
	input logic             req_valid,
	input logic             req_ready,
	input logic             rsp_valid,
	input logic             rsp_ready,
	input logic [OFS_W-1:0] rsp_data_offset,
	input logic [1:0]       rsp_status
);

	// Hold a stalled response: valid and status stay.
	a_rsp_hold: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_status))
		else $error("response dropped or changed while stalled");

	a_status_code: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid |-> rsp_status == ST_GRANT || rsp_status == ST_NOSPACE
			|| rsp_status == ST_FREED)
		else $error("unused status code");

	a_zero_offset: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && rsp_status != ST_GRANT |-> rsp_data_offset == '0)
		else $error("nonzero offset on a non-grant response");

	a_busy_after_accept: assert property (@(posedge clk) disable iff (!arst_n)
		req_valid && req_ready |=> !req_ready)
		else $error("request taken while previous one in flight");

endmodule

bind free_list_heap_allocator flha_checker u_flha_checker (
	.clk            (clk),
	.arst_n         (arst_n),
	.req_valid      (req.valid),
	.req_ready      (req.ready),
	.rsp_valid      (rsp.valid),
	.rsp_ready      (rsp.ready),
	.rsp_data_offset(rsp.data_offset),
	.rsp_status     (rsp.status)
);
